// ----- src/flkg_pkg.sv -----
// Package with register lengths, tap positions, codes and step functions of the keystream generator.
`timescale 1ns / 1ps

package flkg_pkg;

  localparam int unsigned LEN1 = 19;
  localparam int unsigned LEN2 = 22;
  localparam int unsigned LEN3 = 23;
  localparam int unsigned LEN4 = 25;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned FRAME_W = 22;

  // Feedback taps of each register.
  localparam int unsigned T1_A = 18;
  localparam int unsigned T1_B = 17;
  localparam int unsigned T1_C = 16;
  localparam int unsigned T1_D = 13;
  localparam int unsigned T2_A = 21;
  localparam int unsigned T2_B = 20;
  localparam int unsigned T3_A = 22;
  localparam int unsigned T3_B = 21;
  localparam int unsigned T3_C = 20;
  localparam int unsigned T3_D = 7;
  localparam int unsigned T4_A = 24;
  localparam int unsigned T4_B = 17;
  localparam int unsigned T4_C = 7;
  localparam int unsigned T4_D = 3;

  // Bits that form the two-bit clocking decision.
  localparam int unsigned D0_1 = 8;
  localparam int unsigned D0_2 = 10;
  localparam int unsigned D0_3 = 10;
  localparam int unsigned D0_4 = 0;
  localparam int unsigned D1_1 = 5;
  localparam int unsigned D1_2 = 7;
  localparam int unsigned D1_3 = 15;
  localparam int unsigned D1_4 = 12;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_GEN   = 1'b1;

  // Decision codes: each names the register that stays put.
  localparam logic [1:0] DEC_HOLD_THIRD  = 2'd0;
  localparam logic [1:0] DEC_HOLD_FIRST  = 2'd1;
  localparam logic [1:0] DEC_HOLD_SECOND = 2'd2;
  localparam logic [1:0] DEC_HOLD_FOURTH = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_KEY,
    OP_FRAME,
    OP_STEP
  } flkg_op_e;

  function automatic logic [LEN1-1:0] clk_first(logic [LEN1-1:0] r, logic mix);
    return {r[LEN1-2:0], r[T1_A] ^ r[T1_B] ^ r[T1_C] ^ r[T1_D] ^ mix};
  endfunction

  function automatic logic [LEN2-1:0] clk_second(logic [LEN2-1:0] r, logic mix);
    return {r[LEN2-2:0], r[T2_A] ^ r[T2_B] ^ mix};
  endfunction

  function automatic logic [LEN3-1:0] clk_third(logic [LEN3-1:0] r, logic mix);
    return {r[LEN3-2:0], r[T3_A] ^ r[T3_B] ^ r[T3_C] ^ r[T3_D] ^ mix};
  endfunction

  function automatic logic [LEN4-1:0] clk_fourth(logic [LEN4-1:0] r, logic mix);
    return {r[LEN4-2:0], r[T4_A] ^ r[T4_B] ^ r[T4_C] ^ r[T4_D] ^ mix};
  endfunction

endpackage

// ----- src/flkg_if.sv -----
// Channel interfaces of the keystream generator: item input, result output and key write.
`timescale 1ns / 1ps

interface flkg_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [21:0] frame_number;

  modport source (output valid, output mode, output frame_number, input ready);
  modport sink (input valid, input mode, input frame_number, output ready);
endinterface

interface flkg_out_if;
  logic valid;
  logic ready;
  logic keystream_bit;
  logic first_msb;
  logic second_msb;
  logic third_msb;
  logic fourth_msb;

  modport source (output valid, output keystream_bit, output first_msb, output second_msb,
                  output third_msb, output fourth_msb, input ready);
  modport sink (input valid, input keystream_bit, input first_msb, input second_msb,
                input third_msb, input fourth_msb, output ready);
endinterface

interface flkg_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_key;

  modport source (output valid, output cipher_key, input ready);
  modport sink (input valid, input cipher_key, output ready);
endinterface

// ----- src/flkg_ctrl.sv -----
// Controller of the keystream generator: sequences key, frame and warm-up phases, owns handshakes.
`timescale 1ns / 1ps

module flkg_ctrl
  import flkg_pkg::*;
#(
  parameter int unsigned WARMUP_STEPS = 100,
  parameter int unsigned KEY_BITS     = 64,
  parameter int unsigned FRAME_BITS   = 22
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_mode_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output flkg_op_e op_o
);

  localparam int unsigned MAX_KF   = (KEY_BITS > FRAME_BITS) ? KEY_BITS : FRAME_BITS;
  localparam int unsigned MAX_STEP = (MAX_KF > WARMUP_STEPS) ? MAX_KF : WARMUP_STEPS;
  localparam int unsigned CNT_W    = $clog2(MAX_STEP + 1);

  localparam logic [CNT_W-1:0] KEY_LAST   = CNT_W'(KEY_BITS - 1);
  localparam logic [CNT_W-1:0] FRAME_LAST = CNT_W'(FRAME_BITS - 1);
  localparam logic [CNT_W-1:0] WARM_LAST  = CNT_W'(WARMUP_STEPS - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_KEY   = 4'b0010,
    ST_FRAME = 4'b0100,
    ST_WARM  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             in_acc;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    op_o        = OP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_mode_i == MODE_START) begin
            op_o    = OP_LOAD;
            state_d = ST_KEY;
            cnt_d   = '0;
          end else begin
            op_o        = OP_STEP;
            out_valid_d = 1'b1;
          end
        end
      end
      ST_KEY: begin
        op_o = OP_KEY;
        if (cnt_q == KEY_LAST) begin
          state_d = ST_FRAME;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FRAME: begin
        op_o = OP_FRAME;
        if (cnt_q == FRAME_LAST) begin
          state_d = (WARMUP_STEPS == 0) ? ST_IDLE : ST_WARM;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_WARM: begin
        op_o = OP_STEP;
        if (cnt_q == WARM_LAST) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- src/flkg_datapath.sv -----
// Datapath of the keystream generator: key register, the four shift registers and the combiner.
`timescale 1ns / 1ps

module flkg_datapath
  import flkg_pkg::*;
#(
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned FRAME_BITS = 22
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  flkg_op_e           op_i,
  input  logic               cfg_we_i,
  input  logic [KEY_W-1:0]   cfg_key_i,
  input  logic [FRAME_W-1:0] frame_number_i,
  output logic               keystream_bit_o,
  output logic               first_msb_o,
  output logic               second_msb_o,
  output logic               third_msb_o,
  output logic               fourth_msb_o
);

  logic [KEY_W-1:0]      cipher_key_q;
  logic [KEY_BITS-1:0]   key_sh_q, key_sh_d;
  logic [FRAME_BITS-1:0] frame_sh_q, frame_sh_d;
  logic [LEN1-1:0]       r1_q, r1_d;
  logic [LEN2-1:0]       r2_q, r2_d;
  logic [LEN3-1:0]       r3_q, r3_d;
  logic [LEN4-1:0]       r4_q, r4_d;
  logic [1:0]            dec;

  assign dec[0] = r1_q[D0_1] ^ r2_q[D0_2] ^ r3_q[D0_3] ^ r4_q[D0_4];
  assign dec[1] = r1_q[D1_1] ^ r2_q[D1_2] ^ r3_q[D1_3] ^ r4_q[D1_4];

  always_comb begin
    key_sh_d   = key_sh_q;
    frame_sh_d = frame_sh_q;
    r1_d       = r1_q;
    r2_d       = r2_q;
    r3_d       = r3_q;
    r4_d       = r4_q;
    case (op_i)
      OP_LOAD: begin
        key_sh_d   = KEY_BITS'(cipher_key_q);
        frame_sh_d = FRAME_BITS'(frame_number_i);
        r1_d       = '0;
        r2_d       = '0;
        r3_d       = '0;
        r4_d       = '0;
      end
      OP_KEY: begin
        key_sh_d = key_sh_q >> 1;
        r1_d     = clk_first(r1_q, key_sh_q[0]);
        r2_d     = clk_second(r2_q, key_sh_q[0]);
        r3_d     = clk_third(r3_q, key_sh_q[0]);
        r4_d     = clk_fourth(r4_q, key_sh_q[0]);
      end
      OP_FRAME: begin
        frame_sh_d = frame_sh_q >> 1;
        r1_d       = clk_first(r1_q, frame_sh_q[0]);
        r2_d       = clk_second(r2_q, frame_sh_q[0]);
        r3_d       = clk_third(r3_q, frame_sh_q[0]);
        r4_d       = clk_fourth(r4_q, frame_sh_q[0]);
      end
      OP_STEP: begin
        // The decision picks the one register that holds; the other three advance.
        if (dec != DEC_HOLD_FIRST) begin
          r1_d = clk_first(r1_q, 1'b0);
        end
        if (dec != DEC_HOLD_SECOND) begin
          r2_d = clk_second(r2_q, 1'b0);
        end
        if (dec != DEC_HOLD_THIRD) begin
          r3_d = clk_third(r3_q, 1'b0);
        end
        if (dec != DEC_HOLD_FOURTH) begin
          r4_d = clk_fourth(r4_q, 1'b0);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_key_q <= '0;
      r1_q         <= '0;
      r2_q         <= '0;
      r3_q         <= '0;
      r4_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        cipher_key_q <= cfg_key_i;
      end
      r1_q <= r1_d;
      r2_q <= r2_d;
      r3_q <= r3_d;
      r4_q <= r4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_sh_q   <= key_sh_d;
    frame_sh_q <= frame_sh_d;
  end

  // The registers hold still while a result beat is pending, so the top bits are the result.
  assign first_msb_o     = r1_q[LEN1-1];
  assign second_msb_o    = r2_q[LEN2-1];
  assign third_msb_o     = r3_q[LEN3-1];
  assign fourth_msb_o    = r4_q[LEN4-1];
  assign keystream_bit_o = first_msb_o ^ second_msb_o ^ (third_msb_o & fourth_msb_o);

endmodule

// ----- src/four_lfsr_keystream_generator.sv -----
// Top level of the four-register keystream generator.
//
// Channels: in_ch takes items (mode, frame_number), out_ch delivers one result beat per
// generate item, cfg_ch writes the 64-bit cipher key and is always ready.
// A generate item (mode 1) is stepped in the cycle it is accepted and its result beat is
// valid in the next cycle; generate items are taken one per cycle as long as the
// receiver keeps taking results.
// A start item (mode 0) clears the registers and then shifts in KEY_BITS key bits and
// FRAME_BITS frame bits and runs WARMUP_STEPS warm-up steps, one register clock per cycle;
// the input is not ready until this start sequence has finished.
// The controller sequences these phases, one shift of the registers per cycle.
// When the receiver stalls, the pending result stays on out_ch and the next item waits.
// Reset clears the key and all four registers; a generate item right after reset
// therefore yields all-zero results until a start item has run.
// The key may only be written while no start sequence is running.
`timescale 1ns / 1ps

module four_lfsr_keystream_generator
  import flkg_pkg::*;
#(
  parameter int unsigned WARMUP_STEPS = 100,
  parameter int unsigned KEY_BITS     = 64,
  parameter int unsigned FRAME_BITS   = 22
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  flkg_in_if.sink     in_ch,
  flkg_out_if.source  out_ch,
  flkg_cfg_if.sink    cfg_ch
);

  flkg_op_e op;

  assign cfg_ch.ready = 1'b1;

  flkg_ctrl #(
    .WARMUP_STEPS (WARMUP_STEPS),
    .KEY_BITS     (KEY_BITS),
    .FRAME_BITS   (FRAME_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_mode_i   (in_ch.mode),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .op_o        (op)
  );

  flkg_datapath #(
    .KEY_BITS   (KEY_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .cfg_we_i        (cfg_ch.valid),
    .cfg_key_i       (cfg_ch.cipher_key),
    .frame_number_i  (in_ch.frame_number),
    .keystream_bit_o (out_ch.keystream_bit),
    .first_msb_o     (out_ch.first_msb),
    .second_msb_o    (out_ch.second_msb),
    .third_msb_o     (out_ch.third_msb),
    .fourth_msb_o    (out_ch.fourth_msb)
  );

endmodule

// ----- src/flkg_checker.sv -----
// Port-level checker of the keystream generator and its bind to the top level.
`timescale 1ns / 1ps

module flkg_checker
  import flkg_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_mode_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic keystream_bit_i,
  input logic first_msb_i,
  input logic second_msb_i,
  input logic third_msb_i,
  input logic fourth_msb_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A start beat takes input ready away right after it is accepted.
  a_start_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_mode_i == MODE_START) |=> !in_ready_i)
    else $error("input ready right after a start beat");

  // Every generate beat produces a result beat in the next cycle.
  a_gen_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_mode_i == MODE_GEN) |=> out_valid_i)
    else $error("generate beat without a result beat");

  // The keystream bit is the combination of the four shown top bits.
  a_combiner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> keystream_bit_i ==
      (first_msb_i ^ second_msb_i ^ (third_msb_i & fourth_msb_i)))
    else $error("keystream bit does not match the top bits");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(keystream_bit_i)
      && $stable(first_msb_i) && $stable(second_msb_i)
      && $stable(third_msb_i) && $stable(fourth_msb_i))
    else $error("stalled result beat changed");

endmodule

bind four_lfsr_keystream_generator flkg_checker u_flkg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_ch.valid),
  .in_ready_i      (in_ch.ready),
  .in_mode_i       (in_ch.mode),
  .out_valid_i     (out_ch.valid),
  .out_ready_i     (out_ch.ready),
  .keystream_bit_i (out_ch.keystream_bit),
  .first_msb_i     (out_ch.first_msb),
  .second_msb_i    (out_ch.second_msb),
  .third_msb_i     (out_ch.third_msb),
  .fourth_msb_i    (out_ch.fourth_msb)
);

// ----- tb/tb_four_lfsr_keystream_generator.sv -----
// Self-checking testbench of the four-register keystream generator with a bit-exact predictor.
`timescale 1ns / 1ps

module tb_four_lfsr_keystream_generator;
  import flkg_pkg::*;

  localparam int unsigned WARMUP_STEPS  = 100;
  localparam int unsigned KEY_BITS      = 64;
  localparam int unsigned FRAME_BITS    = 22;
  localparam int unsigned START_CYCLES  = WARMUP_STEPS + KEY_BITS + FRAME_BITS;
  localparam int unsigned SETTLE_CYCLES = START_CYCLES + 16;
  localparam int unsigned RANDOM_ITEMS  = 1500;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned TIMEOUT_NS    = 20_000_000;
  localparam int unsigned MAX_PRINTED   = 200;
  localparam logic [21:0] FRAME_MAX     = 22'h3FFFFF;

  localparam logic [24:0] TAPS1 = (25'd1 << T1_A) | (25'd1 << T1_B) | (25'd1 << T1_C) |
                                  (25'd1 << T1_D);
  localparam logic [24:0] TAPS2 = (25'd1 << T2_A) | (25'd1 << T2_B);
  localparam logic [24:0] TAPS3 = (25'd1 << T3_A) | (25'd1 << T3_B) | (25'd1 << T3_C) |
                                  (25'd1 << T3_D);
  localparam logic [24:0] TAPS4 = (25'd1 << T4_A) | (25'd1 << T4_B) | (25'd1 << T4_C) |
                                  (25'd1 << T4_D);

  typedef struct packed {
    logic ks;
    logic msb1;
    logic msb2;
    logic msb3;
    logic msb4;
  } ks_beat_t;

  logic clk;
  logic rst_n;

  flkg_in_if  in_ch ();
  flkg_out_if out_ch ();
  flkg_cfg_if cfg_ch ();

  four_lfsr_keystream_generator #(
    .WARMUP_STEPS(WARMUP_STEPS),
    .KEY_BITS    (KEY_BITS),
    .FRAME_BITS  (FRAME_BITS)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Predicted state of the generator.
  logic [63:0] key_model = '0;
  logic [24:0] lfsr1 = '0;
  logic [24:0] lfsr2 = '0;
  logic [24:0] lfsr3 = '0;
  logic [24:0] lfsr4 = '0;
  ks_beat_t    pending_bits[$];

  int errors        = 0;
  int beats_checked = 0;
  int items_sent    = 0;
  int starts_sent   = 0;
  int keys_written  = 0;
  int holds_done    = 0;
  bit idle_on       = 1'b1;
  bit hold_request  = 1'b0;
  bit hold_active   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [24:0] lfsr_shift(logic [24:0] r, int unsigned len,
                                             logic [24:0] taps, logic mix);
    logic [24:0] mask;
    mask = (25'd1 << len) - 25'd1;
    return ((r << 1) | {24'd0, ^(r & taps) ^ mix}) & mask;
  endfunction

  function automatic void clock_all(logic mix);
    lfsr1 = lfsr_shift(lfsr1, LEN1, TAPS1, mix);
    lfsr2 = lfsr_shift(lfsr2, LEN2, TAPS2, mix);
    lfsr3 = lfsr_shift(lfsr3, LEN3, TAPS3, mix);
    lfsr4 = lfsr_shift(lfsr4, LEN4, TAPS4, mix);
  endfunction

  // Majority-free clocking: the decision names the one register that holds.
  function automatic void irregular_step();
    logic [1:0] dec;
    dec[0] = lfsr1[D0_1] ^ lfsr2[D0_2] ^ lfsr3[D0_3] ^ lfsr4[D0_4];
    dec[1] = lfsr1[D1_1] ^ lfsr2[D1_2] ^ lfsr3[D1_3] ^ lfsr4[D1_4];
    if (dec != DEC_HOLD_FIRST)  lfsr1 = lfsr_shift(lfsr1, LEN1, TAPS1, 1'b0);
    if (dec != DEC_HOLD_SECOND) lfsr2 = lfsr_shift(lfsr2, LEN2, TAPS2, 1'b0);
    if (dec != DEC_HOLD_THIRD)  lfsr3 = lfsr_shift(lfsr3, LEN3, TAPS3, 1'b0);
    if (dec != DEC_HOLD_FOURTH) lfsr4 = lfsr_shift(lfsr4, LEN4, TAPS4, 1'b0);
  endfunction

  function automatic void advance_keystream(logic mode, logic [21:0] frame);
    ks_beat_t beat;
    if (mode == MODE_START) begin
      lfsr1 = '0;
      lfsr2 = '0;
      lfsr3 = '0;
      lfsr4 = '0;
      for (int i = 0; i < KEY_BITS; i++) clock_all(key_model[i]);
      for (int i = 0; i < FRAME_BITS; i++) clock_all((i < FRAME_W) ? frame[i] : 1'b0);
      for (int i = 0; i < WARMUP_STEPS; i++) irregular_step();
    end else begin
      irregular_step();
      beat.msb1 = lfsr1[LEN1-1];
      beat.msb2 = lfsr2[LEN2-1];
      beat.msb3 = lfsr3[LEN3-1];
      beat.msb4 = lfsr4[LEN4-1];
      beat.ks   = beat.msb1 ^ beat.msb2 ^ (beat.msb3 & beat.msb4);
      pending_bits.push_back(beat);
    end
  endfunction

  function automatic logic [63:0] random_key();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [21:0] random_frame();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return FRAME_MAX;
      default: return 22'($urandom_range(0, FRAME_MAX));
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("MISMATCH @%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, int beat_no, logic got, logic want);
    if (got !== want)
      note_mismatch($sformatf("beat %0d %s got %b expected %b", beat_no, name, got, want));
  endtask

  // Result checker: each accepted beat against the oldest prediction.
  always @(posedge clk) begin
    ks_beat_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_bits.size() == 0) begin
        note_mismatch("result beat arrived with nothing expected");
      end else begin
        want = pending_bits.pop_front();
        check_field("keystream_bit", beats_checked, out_ch.keystream_bit, want.ks);
        check_field("first_msb", beats_checked, out_ch.first_msb, want.msb1);
        check_field("second_msb", beats_checked, out_ch.second_msb, want.msb2);
        check_field("third_msb", beats_checked, out_ch.third_msb, want.msb3);
        check_field("fourth_msb", beats_checked, out_ch.fourth_msb, want.msb4);
      end
      beats_checked++;
    end
  end

  // Long receiver hold, counted on rising edges so the ready driver sees a stable flag.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
        holds_done++;
      end
    end
  end

  // Receiver ready with random stall bursts.
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n || hold_active) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Called and returns at a falling edge; valid stays high for a following item.
  task automatic send_item(logic mode, logic [21:0] frame);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.frame_number <= frame;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    advance_keystream(mode, frame);
    items_sent++;
    if (mode == MODE_START) starts_sent++;
    @(negedge clk);
  endtask

  // Drops the input, waits for every expected beat, then lets a start sequence finish.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (pending_bits.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_key(logic [63:0] key);
    settle_block();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.cipher_key <= key;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    key_model = key;
    keys_written++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Registers are still all zero, so every beat must be zero.
  task automatic test_generate_before_start();
    repeat (3) send_item(MODE_GEN, random_frame());
  endtask

  task automatic test_key_and_frame_extremes();
    // An all-zero key and frame leaves the registers at zero.
    write_key('0);
    send_item(MODE_START, '0);
    repeat (2) send_item(MODE_GEN, '0);
    write_key('1);
    send_item(MODE_START, FRAME_MAX);
    repeat (3) send_item(MODE_GEN, FRAME_MAX);
    write_key(64'h1);
    send_item(MODE_START, 22'h1);
    repeat (2) send_item(MODE_GEN, 22'h1);
    write_key(64'h8000_0000_0000_0000);
    send_item(MODE_START, 22'h200000);
    repeat (2) send_item(MODE_GEN, 22'h155555);
  endtask

  // The receiver holds off while generate items keep coming, so the input stalls.
  task automatic test_output_backpressure();
    send_item(MODE_START, random_frame());
    hold_request = 1'b1;
    repeat (24) send_item(MODE_GEN, random_frame());
  endtask

  task automatic test_random_sequences();
    int goal;
    int kind;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      if ($urandom_range(0, 14) == 0) write_key(random_key());
      idle_on = ($urandom_range(0, 4) != 0);
      kind    = $urandom_range(0, 19);
      if (kind < 17) begin
        send_item(MODE_START, random_frame());
        repeat ($urandom_range(1, 40)) send_item(MODE_GEN, random_frame());
      end else if (kind < 19) begin
        repeat ($urandom_range(1, 5)) send_item(MODE_GEN, random_frame());
      end else begin
        // A start with no generate items of its own.
        send_item(MODE_START, random_frame());
      end
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    write_key(random_key());
    send_item(MODE_START, random_frame());
    repeat (80) send_item(MODE_GEN, random_frame());
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_GEN;
    in_ch.frame_number = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.cipher_key  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_generate_before_start();
    test_key_and_frame_extremes();
    test_output_backpressure();
    test_random_sequences();
    test_steady_stream();

    settle_block();
    $display("Sent %0d items (%0d frame starts) under %0d key settings.",
             items_sent, starts_sent, keys_written);
    $display("Checked %0d keystream beats, %0d long receiver holds, %0d mismatches.",
             beats_checked, holds_done, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d beats still expected.", pending_bits.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
